/* rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and character helpers for the integer-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int VAL_W    = 64;          // input value width
  localparam int NDIG     = 20;          // decimal digits of 2**64-1
  localparam int HEX_DIG  = VAL_W / 4;   // hex digits of the value
  localparam int BITS_CYC = 4;           // double-dabble bits per cycle
  localparam int CNT_W    = 5;           // character count / index width
  localparam int UDEC_W   = 32;          // width used by unsigned decimal mode

  // Mode codes carried on in_func
  typedef enum logic [1:0] {
    FN_SDEC = 2'd0,
    FN_UDEC = 2'd1,
    FN_HEX  = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  // ASCII codes
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_LA    = 7'h61;
  localparam logic [6:0] CH_LF    = 7'h66;
  localparam logic [6:0] CH_X     = 7'h78;

  // Classified job passed from the front to the back
  typedef struct packed {
    logic             is_hex;
    logic             neg;
    logic [VAL_W-1:0] mag;
  } itoa_job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } itoa_qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_COUNT,
    BK_EMIT
  } bk_state_t;

  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_LA + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

/* rtl/integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats a 64-bit value as ASCII text: signed decimal, unsigned 32-bit
// decimal, or 0x-prefixed lowercase hex.
// ----------------------------------------------------------------------------
// One input transfer (in_func, in_value) yields a run of character transfers,
// most significant character first; the final one has out_is_last set and
// carries the run length in out_char_count (0 on all others). in_func 0 is
// signed decimal with '-' for negatives (the most negative value prints all
// 19 digits), 1 is unsigned decimal of the low 32 bits, 2 is "0x" plus hex
// without leading zeros, and 3 is accepted but produces no characters. Zero
// prints as "0" after any prefix. Decimal passes a dequeue state, conversion
// and a sizing state, then emits one character per cycle unless out_ready
// stalls (up to 20 characters); hex skips conversion. The binary-to-BCD
// shifter handles 4 bits of the 64-bit magnitude per cycle. The back ends
// one item before it dequeues the next; the front accepts items into a
// QUEUE_DEPTH-entry queue while the back is busy, so in_ready stays high
// until the queue fills; out_ready stalls only the character emitter.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_text_char,
  output logic        out_is_last,
  output logic [4:0]  out_char_count
);
  import itoa_pkg::*;

  itoa_qstat_t q_stat;
  itoa_job_t   push_job, pop_job;
  logic        q_push, q_pop;

  // front: accept and classify
  itoa_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // decoupling queue
  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  // back: digit conversion and character emission
  itoa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_job          (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  // count only shows on the final character of a run
  a_count_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> out_char_count == 5'd0)
    else $error("char count set on a non-final character");

  // a run always ends in a digit
  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |->
      (out_text_char >= CH_ZERO && out_text_char <= CH_NINE) ||
      (out_text_char >= CH_LA && out_text_char <= CH_LF))
    else $error("final character is not a digit");

  // prefix characters never end a run
  a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CH_MINUS || out_text_char == CH_X) |-> !out_is_last)
    else $error("prefix character marked final");

  // a nonzero count covers at least the one digit and never exceeds 20
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_last |-> out_char_count != 5'd0 && out_char_count <= 5'd20)
    else $error("char count out of range");

endmodule

/* rtl/itoa_front.sv */
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input items, decodes the mode and forms the magnitude to convert.
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [63:0]           in_value,
  input  itoa_pkg::itoa_qstat_t q_stat,
  output logic                  q_push,
  output itoa_pkg::itoa_job_t   q_job
);
  import itoa_pkg::*;

  logic take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  always_comb begin
    q_job  = '0;
    q_push = 1'b0;
    case (func_t'(in_func))
      FN_SDEC: begin
        q_push     = take;
        q_job.neg  = in_value[VAL_W-1];
        // two's complement magnitude; the most negative value maps to 2**63
        q_job.mag  = in_value[VAL_W-1] ? (~in_value + 64'd1) : in_value;
      end
      FN_UDEC: begin
        q_push    = take;
        q_job.mag = {{(VAL_W-UDEC_W){1'b0}}, in_value[UDEC_W-1:0]};
      end
      FN_HEX: begin
        q_push       = take;
        q_job.is_hex = 1'b1;
        q_job.mag    = in_value;
      end
      default: begin
        q_push = 1'b0;  // unused mode: accepted, produces nothing
      end
    endcase
  end

endmodule

/* rtl/itoa_queue.sv */
// ----------------------------------------------------------------------------
// itoa_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module itoa_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  itoa_pkg::itoa_job_t   wr_job,
  input  logic                  pop,
  output itoa_pkg::itoa_job_t   rd_job,
  output itoa_pkg::itoa_qstat_t stat
);
  import itoa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  itoa_job_t       ent_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_job     = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

/* rtl/itoa_back.sv */
// ----------------------------------------------------------------------------
// itoa_back
// Converts one job to digits (double-dabble for decimal, direct nibbles for
// hex), sizes the run, then emits characters through an output register.
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itoa_pkg::itoa_qstat_t q_stat,
  input  itoa_pkg::itoa_job_t   q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_text_char,
  output logic                  out_is_last,
  output logic [4:0]            out_char_count
);
  import itoa_pkg::*;

  localparam int CONV_STEPS = VAL_W / BITS_CYC;
  localparam int CONV_CW    = $clog2(CONV_STEPS);

  bk_state_t             state_r, state_nxt;
  logic [NDIG-1:0][3:0]  dig_r, dig_nxt, dig_load, dd_dig;
  logic [VAL_W-1:0]      sh_r, sh_nxt, dd_sh;
  logic [CONV_CW-1:0]    conv_cnt_r, conv_cnt_nxt;
  logic [1:0]            pre_len_r, pre_len_nxt;
  logic                  hex_r, hex_nxt;
  logic [CNT_W-1:0]      len_r, len_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      dig_pos_r, dig_pos_nxt;
  logic [CNT_W-1:0]      ndig_c;
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_char_r, ch_c;
  logic                  out_last_r, last_c;
  logic [CNT_W-1:0]      out_count_r;
  logic                  load_en, conv_en, size_en, emit_go, conv_done, in_prefix;

  assign conv_done = (conv_cnt_r == CONV_CW'(CONV_STEPS-1));
  assign in_prefix = (idx_r < {3'b000, pre_len_r});
  assign last_c    = (idx_r == len_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = q_job.is_hex ? BK_COUNT : BK_CONV;
      BK_CONV:  if (conv_done) state_nxt = BK_COUNT;
      BK_COUNT: state_nxt = BK_EMIT;
      BK_EMIT:  if (emit_go && last_c) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load_en = 1'b0;
    conv_en = 1'b0;
    size_en = 1'b0;
    emit_go = 1'b0;
    case (state_r)
      BK_IDLE:  load_en = !q_stat.empty;
      BK_CONV:  conv_en = 1'b1;
      BK_COUNT: size_en = 1'b1;
      BK_EMIT:  emit_go = !out_valid_r || out_ready;
      default:  load_en = 1'b0;
    endcase
  end

  assign q_pop = load_en;

  // hex digits straight from the nibbles
  always_comb begin
    dig_load = '0;
    for (int d = 0; d < HEX_DIG; d++) begin
      dig_load[d] = q_job.mag[4*d +: 4];
    end
  end

  // four double-dabble steps: adjust every digit, then shift one bit in
  always_comb begin
    dd_dig = dig_r;
    dd_sh  = sh_r;
    for (int k = 0; k < BITS_CYC; k++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dd_dig[d] >= 4'd5) dd_dig[d] = dd_dig[d] + 4'd3;
      end
      for (int d = NDIG-1; d > 0; d--) begin
        dd_dig[d] = {dd_dig[d][2:0], dd_dig[d-1][3]};
      end
      dd_dig[0] = {dd_dig[0][2:0], dd_sh[VAL_W-1]};
      dd_sh     = {dd_sh[VAL_W-2:0], 1'b0};
    end
  end

  // significant digits: highest nonzero digit, at least one
  always_comb begin
    ndig_c = CNT_W'(1);
    for (int d = 1; d < NDIG; d++) begin
      if (dig_r[d] != 4'h0) ndig_c = CNT_W'(d + 1);
    end
  end

  always_comb begin
    if (in_prefix) begin
      if (hex_r) begin
        ch_c = (idx_r == '0) ? CH_ZERO : CH_X;
      end else begin
        ch_c = CH_MINUS;
      end
    end else begin
      ch_c = digit_to_ascii(dig_r[dig_pos_r]);
    end
  end

  always_comb begin
    dig_nxt      = dig_r;
    sh_nxt       = sh_r;
    conv_cnt_nxt = conv_cnt_r;
    pre_len_nxt  = pre_len_r;
    hex_nxt      = hex_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    dig_pos_nxt  = dig_pos_r;
    if (load_en) begin
      hex_nxt      = q_job.is_hex;
      pre_len_nxt  = q_job.is_hex ? 2'd2 : (q_job.neg ? 2'd1 : 2'd0);
      conv_cnt_nxt = '0;
      sh_nxt       = q_job.mag;
      dig_nxt      = q_job.is_hex ? dig_load : '0;
    end
    if (conv_en) begin
      dig_nxt      = dd_dig;
      sh_nxt       = dd_sh;
      conv_cnt_nxt = conv_cnt_r + CONV_CW'(1);
    end
    if (size_en) begin
      len_nxt     = {3'b000, pre_len_r} + ndig_c;
      dig_pos_nxt = ndig_c - CNT_W'(1);
      idx_nxt     = '0;
    end
    if (emit_go) begin
      idx_nxt = idx_r + CNT_W'(1);
      if (!in_prefix) dig_pos_nxt = dig_pos_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    sh_r       <= sh_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    pre_len_r  <= pre_len_nxt;
    hex_r      <= hex_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    dig_pos_r  <= dig_pos_nxt;
    if (emit_go) begin
      out_char_r  <= ch_c;
      out_last_r  <= last_c;
      out_count_r <= last_c ? len_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_text_char  = out_char_r;
  assign out_is_last    = out_last_r;
  assign out_char_count = out_count_r;

endmodule

/* sim/tb_integer_to_ascii_formatter_unit.sv */
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_unit
// Self-checking bench for the integer-to-ASCII formatter. Each accepted
// (func, value) transfer is expanded into its expected character run by a
// predictor in the bench. Every character transfer is checked against the
// oldest pending character. Directed cases come first: zero in each mode,
// signed extremes, low-word truncation, hex width and the unused mode. Then
// random traffic runs with bursty gaps on both sides, a drain pause, and a
// final stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_unit;
  import itoa_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 80;    // wait after the last expected character

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic [4:0] count;
  } char_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FN_SDEC;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_text_char;
  logic        out_is_last;
  logic [4:0]  out_char_count;

  char_rec_t pending_chars[$];  // characters still owed by the block
  int        errors = 0;
  int        quiet_cycles = 0;
  int        out_stall_left = 0;
  bit        gaps_on = 1'b1;    // random gaps on both sides when set

  integer_to_ascii_formatter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_is_last    (out_is_last),
    .out_char_count (out_char_count)
  );

  always #5 clk = ~clk;

  // Expected text of one item, queued most significant character first.
  function automatic void queue_formatted_text(input func_t fn, input logic [63:0] v);
    logic [6:0]  txt [20];
    logic [6:0]  rev [20];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [3:0]  d;
    char_rec_t   rec;
    int          len;
    int          nd;
    int          i;
    len = 0;
    nd  = 0;
    if (fn == FN_NONE) return;
    radix = (fn == FN_HEX) ? 64'd16 : 64'd10;
    case (fn)
      FN_SDEC: begin
        mag = v;
        if (v[63]) begin
          // magnitude taken unsigned, so the most negative value is exact
          txt[len] = CH_MINUS;
          len++;
          mag = ~v + 64'd1;
        end
      end
      FN_UDEC: mag = {32'd0, v[31:0]};
      default: begin
        txt[0] = CH_ZERO;
        txt[1] = CH_X;
        len    = 2;
        mag    = v;
      end
    endcase
    do begin
      d = 4'(mag % radix);
      rev[nd] = (d < 4'd10) ? CH_ZERO + 7'(d) : CH_LA + 7'(d) - 7'd10;
      nd++;
      mag = mag / radix;
    end while (mag != 64'd0);
    for (i = nd - 1; i >= 0; i--) begin
      txt[len] = rev[i];
      len++;
    end
    for (i = 0; i < len; i++) begin
      rec.ch    = txt[i];
      rec.last  = (i == len - 1);
      rec.count = rec.last ? 5'(len) : 5'd0;
      pending_chars.push_back(rec);
    end
  endfunction

  // Values biased toward digit-count and word boundaries.
  function automatic logic [63:0] random_value();
    logic [63:0] p;
    logic [63:0] r;
    int          k;
    case ($urandom_range(0, 5))
      0: r = {$urandom(), $urandom()};
      1: r = 64'($urandom_range(0, 999));
      2: r = -64'($urandom_range(1, 100000));
      3: begin
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        r = $urandom_range(0, 1) ? p : p - 64'd1;
        if ($urandom_range(0, 3) == 0) r = -r;
      end
      4: r = {$urandom(), $urandom()} >> $urandom_range(0, 63);
      default: r = {$urandom(), 32'hFFFF_FFFF} ^ 64'($urandom_range(0, 3));
    endcase
    return r;
  endfunction

  // One input transfer. Valid is left high afterwards so back-to-back items
  // need no second assignment in the same step; a gap lowers it first.
  task automatic send_item(input func_t fn, input logic [63:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= fn;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    queue_formatted_text(fn, v);
  endtask

  task automatic test_zero_each_mode();
    send_item(FN_SDEC, 64'd0);
    send_item(FN_UDEC, 64'd0);
    send_item(FN_HEX, 64'd0);
  endtask

  task automatic test_signed_extremes();
    send_item(FN_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(FN_SDEC, 64'h8000_0000_0000_0000);  // 20 characters
    send_item(FN_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FN_SDEC, 64'd1);
    send_item(FN_SDEC, 64'd9);
    send_item(FN_SDEC, 64'd10);
  endtask

  // Only the low word counts in unsigned mode.
  task automatic test_unsigned_low_word();
    send_item(FN_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_item(FN_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FN_UDEC, 64'h0000_0001_0000_0000);
    send_item(FN_UDEC, 64'hDEAD_BEEF_8000_0000);
  endtask

  task automatic test_hex_width();
    send_item(FN_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FN_HEX, 64'h8000_0000_0000_0000);
    send_item(FN_HEX, 64'h0123_4567_89AB_CDEF);
    send_item(FN_HEX, 64'd1);
    send_item(FN_HEX, 64'h0000_0000_0000_00AF);
  endtask

  // Mode 3 is taken but emits nothing; the next item must still line up.
  task automatic test_unused_mode();
    send_item(FN_NONE, 64'd0);
    send_item(FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FN_SDEC, 64'd42);
  endtask

  task automatic test_drain_pause();
    repeat (4) send_item(func_t'($urandom_range(0, 2)), random_value());
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    @(posedge clk);
    repeat (4) send_item(func_t'($urandom_range(0, 2)), random_value());
  endtask

  // Mostly real modes, a few unused-mode items that do not count.
  task automatic test_random_mix(input int n_items);
    int    sent;
    func_t fn;
    sent = 0;
    while (sent < n_items) begin
      fn = ($urandom_range(0, 11) == 0) ? FN_NONE : func_t'($urandom_range(0, 2));
      send_item(fn, random_value());
      if (fn != FN_NONE) sent++;
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    gaps_on = 1'b0;
    repeat (n_items) send_item(func_t'($urandom_range(0, 2)), random_value());
  endtask

  // Receiver: random stall bursts, checks every character transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char, expected none actual %h last %b count %0d",
                 $time, out_text_char, out_is_last, out_char_count);
        errors++;
      end else begin
        if (out_text_char !== pending_chars[0].ch) begin
          $display("%0t: text_char mismatch, expected %h actual %h",
                   $time, pending_chars[0].ch, out_text_char);
          errors++;
        end
        if (out_is_last !== pending_chars[0].last) begin
          $display("%0t: is_last mismatch, expected %b actual %b",
                   $time, pending_chars[0].last, out_is_last);
          errors++;
        end
        if (out_char_count !== pending_chars[0].count) begin
          $display("%0t: char_count mismatch, expected %0d actual %0d",
                   $time, pending_chars[0].count, out_char_count);
          errors++;
        end
        void'(pending_chars.pop_front());
      end
    end
    if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready      <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      out_stall_left <= $urandom_range(0, 17);
      out_ready      <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: no transfer on either side for too long ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_each_mode();
    test_signed_extremes();
    test_unsigned_low_word();
    test_hex_width();
    test_unused_mode();
    test_drain_pause();
    test_random_mix(160);
    test_back_to_back(30);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
